/* hdl/sapw_pkg.sv */
// Shared definitions for the steepest-ascent path walker.
// Holds grid sizes, field widths, codes, the controller/datapath bundles and the scan table.
// No dependencies.
package sapw_pkg;

    localparam int GRID_X    = 64;
    localparam int GRID_Y    = 64;
    localparam int MAX_STEPS = 64;

    localparam int CELLS  = GRID_X * GRID_Y;
    localparam int X_W    = $clog2(GRID_X);
    localparam int Y_W    = $clog2(GRID_Y);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int CELL_W    = 6;
    localparam int H_W       = 19;
    localparam int RISE_W    = H_W + 1;
    localparam int MAG_W     = H_W;
    localparam int RECIP_W   = 32;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam int SLOPE_W   = 52;
    localparam int OFF_W     = 7;
    localparam int LIM_W     = 7;
    localparam int SLOT_W    = 4;
    localparam int REG_IDX_W = 2;

    // Scan slots: the center cell first, then the eight neighbors in row-major order.
    localparam logic [SLOT_W-1:0] SLOT_CENTER = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_LAST   = 4'd8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_RECIP_DX   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RECIP_DY   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RECIP_DIAG = 2'd2;

    localparam logic [RECIP_W-1:0] RECIP_DX_RESET   = 32'd4294967;
    localparam logic [RECIP_W-1:0] RECIP_DY_RESET   = 32'd4294967;
    localparam logic [RECIP_W-1:0] RECIP_DIAG_RESET = 32'd3037000;

    typedef struct packed {
        logic              wr_cell;
        logic              clr_en;
        logic [ADDR_W-1:0] clr_addr;
        logic              start;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              move;
        logic              emit;
        logic              emit_marker;
        logic              emit_last;
    } sapw_cmd_t;

    typedef struct packed {
        logic start_ok;
        logic pipe_busy;
        logic moved;
        logic out_free;
    } sapw_status_t;

    // Column step of a scan slot: -1, 0 or +1.
    function automatic logic signed [1:0] slot_di(input logic [SLOT_W-1:0] s);
        logic signed [1:0] d;
        case (s)
            4'd1, 4'd4, 4'd6: d = -2'sd1;
            4'd3, 4'd5, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    // Row step of a scan slot: -1, 0 or +1.
    function automatic logic signed [1:0] slot_dj(input logic [SLOT_W-1:0] s);
        logic signed [1:0] d;
        case (s)
            4'd1, 4'd2, 4'd3: d = -2'sd1;
            4'd6, 4'd7, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

/* hdl/sapw_dp.sv */
// Datapath of the path walker: grid memory, reciprocal registers, slope pipeline,
// walk coordinates and the result register. Depends on sapw_pkg.
module sapw_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sapw_pkg::sapw_cmd_t                   cmd,
    output sapw_pkg::sapw_status_t                status,
    input  logic [sapw_pkg::CELL_W-1:0]           cell_i,
    input  logic [sapw_pkg::CELL_W-1:0]           cell_j,
    input  logic signed [sapw_pkg::H_W-1:0]       height,
    input  logic                                  is_icy,
    input  logic                                  cfg_valid,
    input  logic [sapw_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [sapw_pkg::RECIP_W-1:0]          cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sapw_pkg::OFF_W-1:0]     offset_i,
    output logic signed [sapw_pkg::OFF_W-1:0]     offset_j,
    output logic                                  step_valid,
    output logic                                  last
);

    // Each word is {icy, height}; the clearing pass zeroes the ice bit.
    logic [sapw_pkg::H_W:0] mem [sapw_pkg::CELLS];
    logic [sapw_pkg::H_W:0] rd_data_reg;

    logic [sapw_pkg::RECIP_W-1:0] recip_dx_reg, recip_dy_reg, recip_diag_reg;

    logic [sapw_pkg::X_W-1:0] si_reg, ci_reg, bi_reg;
    logic [sapw_pkg::Y_W-1:0] sj_reg, cj_reg, bj_reg;
    logic                     start_ok_reg;

    logic                         s1_valid_reg, s1_ok_reg;
    logic [sapw_pkg::SLOT_W-1:0]  s1_slot_reg;
    logic [sapw_pkg::X_W-1:0]     s1_ni_reg;
    logic [sapw_pkg::Y_W-1:0]     s1_nj_reg;

    logic                         s2_valid_reg, s2_cand_reg;
    logic [sapw_pkg::PROD_W-1:0]  s2_prod_reg;
    logic [sapw_pkg::X_W-1:0]     s2_ni_reg;
    logic [sapw_pkg::Y_W-1:0]     s2_nj_reg;

    logic signed [sapw_pkg::H_W-1:0] hc_reg;
    logic [sapw_pkg::SLOPE_W-1:0]    best_slope_reg;
    logic                            found_reg;

    logic                            out_valid_reg, step_valid_reg, last_reg;
    logic [sapw_pkg::OFF_W-1:0]      off_i_reg, off_j_reg;

    logic                            wr_in_grid, we;
    logic [sapw_pkg::ADDR_W-1:0]     waddr, raddr;
    logic [sapw_pkg::H_W:0]          wdata;
    logic signed [1:0]               di, dj, s1_di, s1_dj;
    logic [sapw_pkg::X_W-1:0]        ni;
    logic [sapw_pkg::Y_W-1:0]        nj;
    logic                            n_ok;
    logic signed [sapw_pkg::RISE_W-1:0] rise;
    logic                            rise_pos;
    logic [sapw_pkg::RECIP_W-1:0]    recip_sel;
    logic [sapw_pkg::SLOPE_W-1:0]    prod_ext;
    logic                            step_start;
    logic                            out_free;

    assign wr_in_grid = (int'(cell_i) < sapw_pkg::GRID_X) && (int'(cell_j) < sapw_pkg::GRID_Y);

    // Write port: clearing pass after reset, otherwise cell writes.
    always_comb
    begin
        we    = cmd.clr_en || (cmd.wr_cell && wr_in_grid);
        waddr = cmd.clr_addr;
        wdata = '0;
        if (!cmd.clr_en)
        begin
            waddr = sapw_pkg::ADDR_W'(sapw_pkg::ADDR_W'(cell_j) * sapw_pkg::ADDR_W'(sapw_pkg::GRID_X))
                  + sapw_pkg::ADDR_W'(cell_i);
            wdata = {is_icy, height};
        end
    end

    // Neighbor coordinates of the slot being issued.
    always_comb
    begin
        di   = sapw_pkg::slot_di(cmd.rd_slot);
        dj   = sapw_pkg::slot_dj(cmd.rd_slot);
        ni   = ci_reg;
        nj   = cj_reg;
        n_ok = 1'b1;
        if (di < 0)
        begin
            ni = ci_reg - 1'b1;
            if (ci_reg == '0)
                n_ok = 1'b0;
        end
        else if (di > 0)
        begin
            ni = ci_reg + 1'b1;
            if (ci_reg == sapw_pkg::X_W'(sapw_pkg::GRID_X - 1))
                n_ok = 1'b0;
        end
        if (dj < 0)
        begin
            nj = cj_reg - 1'b1;
            if (cj_reg == '0)
                n_ok = 1'b0;
        end
        else if (dj > 0)
        begin
            nj = cj_reg + 1'b1;
            if (cj_reg == sapw_pkg::Y_W'(sapw_pkg::GRID_Y - 1))
                n_ok = 1'b0;
        end
        raddr = '0;
        if (n_ok)
            raddr = sapw_pkg::ADDR_W'(sapw_pkg::ADDR_W'(nj) * sapw_pkg::ADDR_W'(sapw_pkg::GRID_X))
                  + sapw_pkg::ADDR_W'(ni);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.rd_en)
            rd_data_reg <= mem[raddr];
    end

    // Rise against the center cell and reciprocal for the slot's direction.
    always_comb
    begin
        s1_di     = sapw_pkg::slot_di(s1_slot_reg);
        s1_dj     = sapw_pkg::slot_dj(s1_slot_reg);
        rise      = sapw_pkg::RISE_W'(signed'(rd_data_reg[sapw_pkg::H_W-1:0]))
                  - sapw_pkg::RISE_W'(hc_reg);
        rise_pos  = !rise[sapw_pkg::RISE_W-1] && (rise != '0);
        if (s1_di == 0)
            recip_sel = recip_dy_reg;
        else if (s1_dj == 0)
            recip_sel = recip_dx_reg;
        else
            recip_sel = recip_diag_reg;
        prod_ext   = sapw_pkg::SLOPE_W'(s2_prod_reg);
        step_start = cmd.rd_en && (cmd.rd_slot == sapw_pkg::SLOT_CENTER);
        out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip_dx_reg   <= sapw_pkg::RECIP_DX_RESET;
            recip_dy_reg   <= sapw_pkg::RECIP_DY_RESET;
            recip_diag_reg <= sapw_pkg::RECIP_DIAG_RESET;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            start_ok_reg   <= 1'b0;
            ci_reg         <= '0;
            cj_reg         <= '0;
            best_slope_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    sapw_pkg::REG_RECIP_DX:   recip_dx_reg   <= cfg_data;
                    sapw_pkg::REG_RECIP_DY:   recip_dy_reg   <= cfg_data;
                    sapw_pkg::REG_RECIP_DIAG: recip_diag_reg <= cfg_data;
                    default:                  ;
                endcase
            end

            if (cmd.start)
            begin
                start_ok_reg <= wr_in_grid;
                ci_reg       <= sapw_pkg::X_W'(cell_i);
                cj_reg       <= sapw_pkg::Y_W'(cell_j);
            end
            else if (cmd.move)
            begin
                ci_reg <= bi_reg;
                cj_reg <= bj_reg;
            end

            s1_valid_reg <= cmd.rd_en && (cmd.rd_slot != sapw_pkg::SLOT_CENTER);
            s2_valid_reg <= s1_valid_reg;

            if (step_start)
            begin
                best_slope_reg <= '0;
                found_reg      <= 1'b0;
            end
            else if (s2_valid_reg && s2_cand_reg && (prod_ext > best_slope_reg))
            begin
                best_slope_reg <= prod_ext;
                found_reg      <= 1'b1;
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            si_reg <= sapw_pkg::X_W'(cell_i);
            sj_reg <= sapw_pkg::Y_W'(cell_j);
        end

        if (cmd.rd_en)
        begin
            s1_ok_reg   <= n_ok;
            s1_slot_reg <= cmd.rd_slot;
            s1_ni_reg   <= ni;
            s1_nj_reg   <= nj;
        end

        // The center height is registered as the first neighbor's read data lands, ready for its rise.
        if (s1_slot_reg == sapw_pkg::SLOT_CENTER)
            hc_reg <= signed'(rd_data_reg[sapw_pkg::H_W-1:0]);

        s2_cand_reg <= s1_ok_reg && rd_data_reg[sapw_pkg::H_W] && rise_pos;
        s2_prod_reg <= rise[sapw_pkg::MAG_W-1:0] * recip_sel;
        s2_ni_reg   <= s1_ni_reg;
        s2_nj_reg   <= s1_nj_reg;

        if (!step_start && s2_valid_reg && s2_cand_reg && (prod_ext > best_slope_reg))
        begin
            bi_reg <= s2_ni_reg;
            bj_reg <= s2_nj_reg;
        end

        if (cmd.emit)
        begin
            step_valid_reg <= !cmd.emit_marker;
            last_reg       <= cmd.emit_last;
            if (cmd.emit_marker)
            begin
                off_i_reg <= '0;
                off_j_reg <= '0;
            end
            else
            begin
                off_i_reg <= sapw_pkg::OFF_W'(ci_reg) - sapw_pkg::OFF_W'(si_reg);
                off_j_reg <= sapw_pkg::OFF_W'(cj_reg) - sapw_pkg::OFF_W'(sj_reg);
            end
        end
    end

    assign status.start_ok  = start_ok_reg;
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign status.moved     = found_reg;
    assign status.out_free  = out_free;

    assign out_valid  = out_valid_reg;
    assign offset_i   = signed'(off_i_reg);
    assign offset_j   = signed'(off_j_reg);
    assign step_valid = step_valid_reg;
    assign last       = last_reg;

endmodule

/* hdl/sapw_ctrl.sv */
// Controller of the path walker: clearing pass, query sequencing, scan issue and result emission.
// Depends on sapw_pkg; drives sapw_dp through the command bundle.
module sapw_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [sapw_pkg::LIM_W-1:0]    max_steps,
    input  sapw_pkg::sapw_status_t        status,
    output sapw_pkg::sapw_cmd_t           cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_START  = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_DECIDE = 7'b0100000,
        S_LAST   = 7'b1000000
    } sapw_state_t;

    sapw_state_t                   state_reg, state_next;
    logic [sapw_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [sapw_pkg::LIM_W-1:0]    n_reg, n_next;
    logic [sapw_pkg::LIM_W-1:0]    limit_reg, limit_next;
    logic [sapw_pkg::ADDR_W-1:0]   clr_reg, clr_next;
    logic                          accept;
    logic [sapw_pkg::LIM_W-1:0]    n_inc;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign n_inc    = n_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        n_next     = n_reg;
        limit_next = limit_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        cmd.clr_addr = clr_reg;
        cmd.rd_slot  = slot_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == sapw_pkg::ADDR_W'(sapw_pkg::CELLS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == sapw_pkg::OP_WRITE)
                        cmd.wr_cell = 1'b1;
                    else
                    begin
                        cmd.start  = 1'b1;
                        n_next     = '0;
                        limit_next = (max_steps > sapw_pkg::LIM_W'(sapw_pkg::MAX_STEPS))
                                   ? sapw_pkg::LIM_W'(sapw_pkg::MAX_STEPS) : max_steps;
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if (status.start_ok && (limit_reg != '0))
                begin
                    slot_next  = sapw_pkg::SLOT_CENTER;
                    state_next = S_SCAN;
                end
                else if (status.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_marker = 1'b1;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (slot_reg == sapw_pkg::SLOT_LAST)
                    state_next = S_DRAIN;
                else
                    slot_next = slot_reg + 1'b1;
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.out_free)
                begin
                    if (status.moved)
                    begin
                        // The previous move is known not to be the final one now.
                        cmd.emit = (n_reg != '0);
                        cmd.move = 1'b1;
                        n_next   = n_inc;
                        if (n_inc == limit_reg)
                            state_next = S_LAST;
                        else
                        begin
                            slot_next  = sapw_pkg::SLOT_CENTER;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_marker = (n_reg == '0);
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            slot_reg  <= '0;
            n_reg     <= '0;
            limit_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            n_reg     <= n_next;
            limit_reg <= limit_next;
            clr_reg   <= clr_next;
        end
    end

    a_steps_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= limit_reg)
        else $error("step count ran past the query limit");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted while the output register was still full");

    a_limit_goes_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && status.out_free && status.moved && n_inc == limit_reg)
        |=> (state_reg == S_LAST))
        else $error("move reaching the limit did not close the query");

    a_scan_on_empty_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && slot_reg == sapw_pkg::SLOT_CENTER) |-> !status.pipe_busy)
        else $error("new step started while the slope pipeline still held beats");

endmodule

/* hdl/steepest_ascent_path_walker.sv */
// Steepest-ascent path walker: a write stores one grid cell; a query scans each step with
// nine grid reads through the single memory read port, a drain of the slope pipeline and
// a decision, with an extra state for the final move when the walk ends at its step limit.
// Results leave one per move, or one marker beat for a walk with no move, through an output
// register; back pressure stalls the walk. After reset a clearing pass over all 4096 cells zeroes
// the ice marks; no input beat is taken meanwhile, while configuration beats are taken at any time.
module steepest_ascent_path_walker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic [sapw_pkg::CELL_W-1:0]           cell_i,
    input  logic [sapw_pkg::CELL_W-1:0]           cell_j,
    input  logic signed [sapw_pkg::H_W-1:0]       height,
    input  logic                                  is_icy,
    input  logic [sapw_pkg::LIM_W-1:0]            max_steps,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sapw_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [sapw_pkg::RECIP_W-1:0]          cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sapw_pkg::OFF_W-1:0]     offset_i,
    output logic signed [sapw_pkg::OFF_W-1:0]     offset_j,
    output logic                                  step_valid,
    output logic                                  last
);

    sapw_pkg::sapw_cmd_t    cmd;
    sapw_pkg::sapw_status_t status;

    assign cfg_ready = 1'b1;

    sapw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .max_steps (max_steps),
        .status    (status),
        .cmd       (cmd)
    );

    sapw_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cell_i     (cell_i),
        .cell_j     (cell_j),
        .height     (height),
        .is_icy     (is_icy),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .offset_i   (offset_i),
        .offset_j   (offset_j),
        .step_valid (step_valid),
        .last       (last)
    );

endmodule

/* test/steepest_ascent_path_walker_tb.sv */
`timescale 1ns / 100ps
// Testbench for the steepest-ascent path walker: grid writes, path queries and register writes.
// Predicts every step of each walk and checks the result beats in order.
// Depends on sapw_pkg and steepest_ascent_path_walker.
module steepest_ascent_path_walker_tb;

    typedef struct packed {
        logic signed [sapw_pkg::OFF_W-1:0] off_i;
        logic signed [sapw_pkg::OFF_W-1:0] off_j;
        logic                              step_valid;
        logic                              last;
    } step_t;

    // Keeps its own copy of the grid and registers and predicts each walk.
    class ascent_tracker;
        logic signed [sapw_pkg::H_W-1:0] heights [sapw_pkg::CELLS];
        bit                              icy [sapw_pkg::CELLS];
        logic [sapw_pkg::RECIP_W-1:0]    recip_dx;
        logic [sapw_pkg::RECIP_W-1:0]    recip_dy;
        logic [sapw_pkg::RECIP_W-1:0]    recip_diag;
        step_t                           expected_moves [$];
        int                              errors;

        function new();
            recip_dx   = sapw_pkg::RECIP_DX_RESET;
            recip_dy   = sapw_pkg::RECIP_DY_RESET;
            recip_diag = sapw_pkg::RECIP_DIAG_RESET;
            errors     = 0;
        endfunction

        function void set_recip(logic [sapw_pkg::REG_IDX_W-1:0] idx,
                                logic [sapw_pkg::RECIP_W-1:0] val);
            case (idx)
                sapw_pkg::REG_RECIP_DX:   recip_dx = val;
                sapw_pkg::REG_RECIP_DY:   recip_dy = val;
                sapw_pkg::REG_RECIP_DIAG: recip_diag = val;
                default:                  ;
            endcase
        endfunction

        function int pending();
            return expected_moves.size();
        endfunction

        function void note_request(logic op, logic [sapw_pkg::CELL_W-1:0] ci,
                                   logic [sapw_pkg::CELL_W-1:0] cj,
                                   logic signed [sapw_pkg::H_W-1:0] h, logic icy_in,
                                   logic [sapw_pkg::LIM_W-1:0] lim);
            int          limit;
            int          moves;
            int          x, y, bx, by, nx, ny, rise, k;
            int          path_i [sapw_pkg::MAX_STEPS];
            int          path_j [sapw_pkg::MAX_STEPS];
            logic [63:0] best;
            logic [63:0] slope;
            logic [sapw_pkg::RECIP_W-1:0] recip;
            step_t       s;
            if (op == sapw_pkg::OP_WRITE) begin
                if (int'(ci) < sapw_pkg::GRID_X && int'(cj) < sapw_pkg::GRID_Y) begin
                    heights[int'(cj) * sapw_pkg::GRID_X + int'(ci)] = h;
                    icy[int'(cj) * sapw_pkg::GRID_X + int'(ci)] = icy_in;
                end
                return;
            end
            limit = (int'(lim) > sapw_pkg::MAX_STEPS) ? sapw_pkg::MAX_STEPS : int'(lim);
            x = int'(ci);
            y = int'(cj);
            moves = 0;
            if (int'(ci) < sapw_pkg::GRID_X && int'(cj) < sapw_pkg::GRID_Y) begin
                while (moves < limit) begin
                    best = 0;
                    bx = x;
                    by = y;
                    for (int dj = -1; dj <= 1; dj++) begin
                        for (int di = -1; di <= 1; di++) begin
                            nx = x + di;
                            ny = y + dj;
                            if (di == 0 && dj == 0) continue;
                            if (nx < 0 || ny < 0 || nx >= sapw_pkg::GRID_X
                                || ny >= sapw_pkg::GRID_Y) continue;
                            if (!icy[ny * sapw_pkg::GRID_X + nx]) continue;
                            rise = int'(heights[ny * sapw_pkg::GRID_X + nx])
                                 - int'(heights[y * sapw_pkg::GRID_X + x]);
                            if (rise <= 0) continue;
                            if (di == 0)      recip = recip_dy;
                            else if (dj == 0) recip = recip_dx;
                            else              recip = recip_diag;
                            slope = 64'(rise) * 64'(recip);
                            if (slope > best) begin
                                best = slope;
                                bx = nx;
                                by = ny;
                            end
                        end
                    end
                    if (bx == x && by == y) break;
                    x = bx;
                    y = by;
                    path_i[moves] = x - int'(ci);
                    path_j[moves] = y - int'(cj);
                    moves++;
                end
            end
            if (moves == 0) begin
                s = '{off_i: '0, off_j: '0, step_valid: 1'b0, last: 1'b1};
                expected_moves.insert(expected_moves.size(), s);
            end else begin
                for (k = 0; k < moves; k++) begin
                    s.off_i      = sapw_pkg::OFF_W'(path_i[k]);
                    s.off_j      = sapw_pkg::OFF_W'(path_j[k]);
                    s.step_valid = 1'b1;
                    s.last       = (k == moves - 1);
                    expected_moves.insert(expected_moves.size(), s);
                end
            end
        endfunction

        function void check_step(step_t got);
            step_t want;
            if (expected_moves.size() == 0) begin
                $error("result beat arrived with no step expected");
                errors++;
                return;
            end
            want = expected_moves.pop_front();
            if (got.off_i !== want.off_i) begin
                $error("offset_i: expected %0d, got %0d", want.off_i, got.off_i);
                errors++;
            end
            if (got.off_j !== want.off_j) begin
                $error("offset_j: expected %0d, got %0d", want.off_j, got.off_j);
                errors++;
            end
            if (got.step_valid !== want.step_valid) begin
                $error("step_valid: expected %0d, got %0d", want.step_valid, got.step_valid);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic                                 opcode = sapw_pkg::OP_WRITE;
    logic [sapw_pkg::CELL_W-1:0]          cell_i = '0;
    logic [sapw_pkg::CELL_W-1:0]          cell_j = '0;
    logic signed [sapw_pkg::H_W-1:0]      height = '0;
    logic                                 is_icy = 1'b0;
    logic [sapw_pkg::LIM_W-1:0]           max_steps = '0;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [sapw_pkg::REG_IDX_W-1:0]       cfg_index = sapw_pkg::REG_RECIP_DX;
    logic [sapw_pkg::RECIP_W-1:0]         cfg_data = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [sapw_pkg::OFF_W-1:0]    offset_i;
    logic signed [sapw_pkg::OFF_W-1:0]    offset_j;
    logic                                 step_valid;
    logic                                 last;

    ascent_tracker tracker = new();
    int  gap_pct = 7;
    int  stall_pct = 51;
    int  beats_sent = 0;
    bit  cell_seen [sapw_pkg::CELLS];
    int  written_cells [$];

    steepest_ascent_path_walker u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .cell_i     (cell_i),
        .cell_j     (cell_j),
        .height     (height),
        .is_icy     (is_icy),
        .max_steps  (max_steps),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .offset_i   (offset_i),
        .offset_j   (offset_j),
        .step_valid (step_valid),
        .last       (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready = (int'($urandom_range(99)) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_step(step_t'{offset_i, offset_j, step_valid, last});
        end
    end

    function automatic int rnd(int lo, int hi);
        return int'($urandom_range(hi, lo));
    endfunction

    function automatic logic signed [sapw_pkg::H_W-1:0] fit_height(int v);
        if (v > 262143) return 19'sd262143;
        if (v < -262144) return -19'sd262144;
        return sapw_pkg::H_W'(v);
    endfunction

    task automatic send_beat(input logic op, input int x, input int y,
                             input logic signed [sapw_pkg::H_W-1:0] h, input logic icy_in,
                             input logic [sapw_pkg::LIM_W-1:0] lim);
        @(negedge clk);
        while (rnd(0, 99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        opcode    = op;
        cell_i    = sapw_pkg::CELL_W'(x);
        cell_j    = sapw_pkg::CELL_W'(y);
        height    = h;
        is_icy    = icy_in;
        max_steps = lim;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_request(op, sapw_pkg::CELL_W'(x), sapw_pkg::CELL_W'(y), h, icy_in, lim);
        if (op == sapw_pkg::OP_WRITE && !cell_seen[y * sapw_pkg::GRID_X + x])
        begin
            cell_seen[y * sapw_pkg::GRID_X + x] = 1'b1;
            written_cells.insert(written_cells.size(), y * sapw_pkg::GRID_X + x);
        end
        beats_sent++;
    endtask

    task automatic write_cell(input int x, input int y, input int h, input bit icy_in);
        send_beat(sapw_pkg::OP_WRITE, x, y, fit_height(h), icy_in,
                  sapw_pkg::LIM_W'(rnd(0, 127)));
    endtask

    // Height and ice fields are don't-care on a query, so they carry noise.
    task automatic query_path(input int x, input int y, input int lim);
        send_beat(sapw_pkg::OP_QUERY, x, y, sapw_pkg::H_W'($urandom),
                  1'($urandom_range(1)), sapw_pkg::LIM_W'(lim));
    endtask

    task automatic query_written(input int lim);
        int idx;
        idx = written_cells[rnd(0, written_cells.size() - 1)];
        query_path(idx % sapw_pkg::GRID_X, idx / sapw_pkg::GRID_X, lim);
    endtask

    task automatic write_recip(input logic [sapw_pkg::REG_IDX_W-1:0] idx,
                               input logic [sapw_pkg::RECIP_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.set_recip(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // A write leaves no result behind, so the wait goes on past the last expected step.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic int random_limit();
        return (rnd(0, 9) < 3) ? rnd(0, 127) : rnd(0, 64);
    endfunction

    // A rectangular patch, either a tilted ramp with noise or rough terrain, then one to three walks.
    task automatic run_patch(input bit ramp);
        int w, hh, ox, oy, sx, sy, stp, base, nq, hgt, qx, qy;
        w  = rnd(3, 8);
        hh = rnd(3, 8);
        case (rnd(0, 3))
            0:       ox = 0;
            1:       ox = sapw_pkg::GRID_X - w;
            default: ox = rnd(0, sapw_pkg::GRID_X - w);
        endcase
        case (rnd(0, 3))
            0:       oy = 0;
            1:       oy = sapw_pkg::GRID_Y - hh;
            default: oy = rnd(0, sapw_pkg::GRID_Y - hh);
        endcase
        sx = rnd(0, 2) - 1;
        sy = rnd(0, 2) - 1;
        if (sx == 0 && sy == 0) sx = 1;
        stp  = rnd(1, 4000);
        base = rnd(0, 400000) - 200000;
        for (int y = 0; y < hh; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                if (ramp)
                    hgt = base + (sx * x + sy * y) * stp + rnd(0, stp / 2);
                else if (rnd(0, 1) == 1)
                    hgt = rnd(0, 524287) - 262144;
                else
                    hgt = rnd(0, 3);
                write_cell(ox + x, oy + y, hgt, rnd(0, 9) != 0);
            end
        end
        nq = rnd(1, 3);
        for (int q = 0; q < nq; q++)
        begin
            qx = ox + rnd(0, w - 1);
            qy = oy + rnd(0, hh - 1);
            if (ramp && rnd(0, 1) == 1)
            begin
                if (sx > 0) qx = ox;
                if (sx < 0) qx = ox + w - 1;
                if (sy > 0) qy = oy;
                if (sy < 0) qy = oy + hh - 1;
            end
            query_path(qx, qy, random_limit());
        end
    endtask

    // An L-shaped ramp long enough to run a walk into the step limit.
    task automatic run_l_ramp();
        int r, c0, hl, vl, stp, base, k;
        r    = rnd(0, 20);
        c0   = rnd(0, 15);
        hl   = rnd(30, 45);
        vl   = rnd(37, 42);
        stp  = rnd(1, 2000);
        base = rnd(0, 60000) - 30000;
        k    = 0;
        for (int i = 0; i < hl; i++)
        begin
            write_cell(c0 + i, r, base + k * stp, 1'b1);
            k++;
        end
        for (int j = 1; j <= vl; j++)
        begin
            write_cell(c0 + hl - 1, r + j, base + k * stp, 1'b1);
            k++;
        end
        query_path(c0, r, rnd(65, 127));
        query_path(c0, r, sapw_pkg::MAX_STEPS);
        query_path(c0 + rnd(0, hl - 1), r, random_limit());
    endtask

    initial
    begin
        int phase_start;
        logic [sapw_pkg::RECIP_W-1:0] rv;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Tie break: eight equally high neighbors; (10,9), first straight one in scan order, wins.
        write_cell(10, 10, 0, 1'b1);
        for (int dj = -1; dj <= 1; dj++)
            for (int di = -1; di <= 1; di++)
                if (di != 0 || dj != 0) write_cell(10 + di, 10 + dj, 16, 1'b1);
        query_path(10, 10, 5);
        query_path(10, 10, 0);
        query_path(10, 9, 3);
        // Height extremes at the grid corners.
        write_cell(0, 0, -262144, 1'b1);
        write_cell(1, 1, 262143, 1'b1);
        write_cell(62, 62, -262144, 1'b1);
        write_cell(63, 63, 262143, 1'b1);
        query_path(0, 0, 127);
        query_path(62, 62, sapw_pkg::MAX_STEPS);
        // A higher neighbor without ice is passed over.
        write_cell(30, 30, 0, 1'b1);
        write_cell(31, 30, 100, 1'b0);
        write_cell(29, 31, 50, 1'b1);
        query_path(30, 30, 4);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            gap_pct   = (p < 2) ? 7 : (p < 4) ? 51 : 0;
            stall_pct = (p < 2) ? 51 : (p < 4) ? 7 : 0;
            rv = $urandom;
            case (p)
                0: begin
                    write_recip(sapw_pkg::REG_RECIP_DX, $urandom);
                    write_recip(sapw_pkg::REG_RECIP_DY, $urandom);
                    write_recip(sapw_pkg::REG_RECIP_DIAG, $urandom);
                end
                1: begin
                    write_recip(sapw_pkg::REG_RECIP_DX, '1);
                    write_recip(sapw_pkg::REG_RECIP_DY, '1);
                    write_recip(sapw_pkg::REG_RECIP_DIAG, '1);
                end
                2: begin
                    write_recip(sapw_pkg::REG_RECIP_DX, '0);
                    write_recip(sapw_pkg::REG_RECIP_DY, '0);
                    write_recip(sapw_pkg::REG_RECIP_DIAG, '0);
                end
                3: begin
                    write_recip(sapw_pkg::REG_RECIP_DX, '0);
                    write_recip(sapw_pkg::REG_RECIP_DY, '1);
                    write_recip(sapw_pkg::REG_RECIP_DIAG, rv);
                end
                4: begin
                    write_recip(sapw_pkg::REG_RECIP_DX, rv);
                    write_recip(sapw_pkg::REG_RECIP_DY, rv);
                    write_recip(sapw_pkg::REG_RECIP_DIAG, rv);
                end
                default: begin
                    write_recip(sapw_pkg::REG_RECIP_DX, sapw_pkg::RECIP_DX_RESET);
                    write_recip(sapw_pkg::REG_RECIP_DY, sapw_pkg::RECIP_DY_RESET);
                    write_recip(sapw_pkg::REG_RECIP_DIAG, sapw_pkg::RECIP_DIAG_RESET);
                end
            endcase
            phase_start = beats_sent;
            if (p == 0) run_l_ramp();
            while (beats_sent - phase_start < 45)
            begin
                case (rnd(0, 9))
                    0, 1: begin
                        repeat (rnd(1, 6))
                            write_cell(rnd(0, sapw_pkg::GRID_X - 1),
                                       rnd(0, sapw_pkg::GRID_Y - 1),
                                       rnd(0, 524287) - 262144, rnd(0, 1) == 1);
                        query_written(rnd(0, 127));
                    end
                    2, 3, 4: run_patch(1'b0);
                    9:       run_l_ramp();
                    default: run_patch(1'b1);
                endcase
            end
        end

        settle();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
